@@ design/psrpd_pkg.sv @@
// Package with the shared types and constants of the per-source rate and port-scan detector.
`timescale 1ns / 1ps
package psrpd_pkg;

  localparam int ADDR_W  = 64;
  localparam int PORT_W  = 16;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;
  localparam int PCNT_W  = 7;   // holds a port count up to the largest slot size
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 2;

  // Register indexes of the configuration port.
  localparam logic [CIDX_W-1:0] REG_MODE        = 2'd0;
  localparam logic [CIDX_W-1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_FIND_WINDOW = 2'd2;
  localparam logic [CIDX_W-1:0] REG_SCOPE_PORT  = 2'd3;

  // Detection modes. The last code has no meaning and ignores every event.
  localparam logic [1:0] MODE_RATE   = 2'd0;
  localparam logic [1:0] MODE_PORTS  = 2'd1;
  localparam logic [1:0] MODE_SCOPED = 2'd2;
  localparam logic [1:0] MODE_OFF    = 2'd3;

  localparam logic [1:0]         RST_MODE        = MODE_RATE;
  localparam logic [COUNT_W-1:0] RST_THRESHOLD   = 32'd20;
  localparam logic [TIME_W-1:0]  RST_FIND_WINDOW = 32'd10;
  localparam logic [PORT_W-1:0]  RST_SCOPE_PORT  = 16'd0;

  typedef enum logic [2:0] {
    OUT_NEW     = 3'd0,
    OUT_RESTART = 3'd1,
    OUT_COUNTED = 3'd2,
    OUT_TRIGGER = 3'd3,
    OUT_SEEN    = 3'd4,
    OUT_IGNORED = 3'd5
  } outcome_t;

  typedef struct packed {
    logic               used;
    logic               ver;
    logic [ADDR_W-1:0]  hi;
    logic [ADDR_W-1:0]  lo;
    logic [TIME_W-1:0]  wstart;
    logic [COUNT_W-1:0] ecnt;
    logic [PCNT_W-1:0]  pcnt;
    logic [TIME_W-1:0]  last;
  } row_t;

  typedef struct packed {
    logic clr;
    logic ld_item;
    logic prb_start;
    logic prb_chk;
    logic evc_chk;
    logic prt_start;
    logic prt_chk;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ignored;
    logic prb_hit;
    logic prb_last;
    logic evc_free;
    logic evc_last;
    logic need_ports;
    logic prt_match;
    logic prt_last;
    logic out_busy;
  } status_t;

endpackage

@@ design/psrpd_item_if.sv @@
// Channel interface for one input event item.
`timescale 1ns / 1ps
interface psrpd_item_if;
  logic        valid;
  logic        ready;
  logic        ip_version;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [15:0] dest_port;
  logic [31:0] now_sec;

  modport source (output valid, ip_version, addr_high, addr_low, dest_port, now_sec,
                  input ready);
  modport sink (input valid, ip_version, addr_high, addr_low, dest_port, now_sec,
                output ready);
endinterface

@@ design/psrpd_result_if.sv @@
// Channel interface for one detector result item.
`timescale 1ns / 1ps
interface psrpd_result_if #(parameter int SLOT_W = 10);
  logic              valid;
  logic              ready;
  logic [2:0]        outcome;
  logic              trigger;
  logic [31:0]       count_value;
  logic [SLOT_W-1:0] slot;
  logic              replaced_other;

  modport source (output valid, outcome, trigger, count_value, slot, replaced_other,
                  input ready);
  modport sink (input valid, outcome, trigger, count_value, slot, replaced_other,
                output ready);
endinterface

@@ design/psrpd_ctrl.sv @@
// Controller state machine that sequences lookup, eviction, port scan and update.
`timescale 1ns / 1ps
module psrpd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  psrpd_pkg::status_t st,
  output psrpd_pkg::cmd_t    cmd
);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b00000000001,
    S_IDLE    = 11'b00000000010,
    S_START   = 11'b00000000100,
    S_PRB_RD  = 11'b00000001000,
    S_PRB_CHK = 11'b00000010000,
    S_EVC_RD  = 11'b00000100000,
    S_EVC_CHK = 11'b00001000000,
    S_DECIDE  = 11'b00010000000,
    S_PRT_RD  = 11'b00100000000,
    S_PRT_CHK = 11'b01000000000,
    S_UPDATE  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        if (st.ignored) begin
          state_next = S_UPDATE;
        end else begin
          cmd.prb_start = 1'b1;
          state_next    = S_PRB_RD;
        end
      end
      S_PRB_RD: state_next = S_PRB_CHK;
      S_PRB_CHK: begin
        cmd.prb_chk = 1'b1;
        if (st.prb_hit) state_next = S_DECIDE;
        else if (st.prb_last) state_next = S_EVC_RD;
        else state_next = S_PRB_RD;
      end
      S_EVC_RD: state_next = S_EVC_CHK;
      S_EVC_CHK: begin
        cmd.evc_chk = 1'b1;
        if (st.evc_free || st.evc_last) state_next = S_UPDATE;
        else state_next = S_EVC_RD;
      end
      S_DECIDE: begin
        if (st.need_ports) begin
          cmd.prt_start = 1'b1;
          state_next    = S_PRT_RD;
        end else begin
          state_next = S_UPDATE;
        end
      end
      S_PRT_RD: state_next = S_PRT_CHK;
      S_PRT_CHK: begin
        cmd.prt_chk = 1'b1;
        if (st.prt_match || st.prt_last) state_next = S_UPDATE;
        else state_next = S_PRT_RD;
      end
      S_UPDATE: begin
        if (!st.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

@@ design/psrpd_dp.sv @@
// Datapath with the slot table, the port store, config registers and the result register.
`timescale 1ns / 1ps
module psrpd_dp #(
  parameter int TABLE_DEPTH    = 1024,
  parameter int PORTS_PER_SLOT = 64,
  parameter int EVICT_SCAN     = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr,
  input  logic [psrpd_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [psrpd_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                  in_ver,
  input  logic [psrpd_pkg::ADDR_W-1:0]          in_hi,
  input  logic [psrpd_pkg::ADDR_W-1:0]          in_lo,
  input  logic [psrpd_pkg::PORT_W-1:0]          in_port,
  input  logic [psrpd_pkg::TIME_W-1:0]          in_now,
  input  psrpd_pkg::cmd_t                       cmd,
  output psrpd_pkg::status_t                    st,
  psrpd_result_if.source                        res
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PI_W  = $clog2(PORTS_PER_SLOT);
  localparam int SC_W  = (EVICT_SCAN > 1) ? $clog2(EVICT_SCAN) : 1;
  localparam int NCH   = (psrpd_pkg::ADDR_W + IDX_W - 1) / IDX_W;
  localparam int PDEPTH = TABLE_DEPTH * (2 ** PI_W);
  localparam logic [psrpd_pkg::PCNT_W-1:0] PPS = psrpd_pkg::PCNT_W'(PORTS_PER_SLOT);

  // Configuration registers.
  logic [1:0]                     mode;
  logic [psrpd_pkg::COUNT_W-1:0]  threshold;
  logic [psrpd_pkg::TIME_W-1:0]   find_window;
  logic [psrpd_pkg::PORT_W-1:0]   scope_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= psrpd_pkg::RST_MODE;
      threshold   <= psrpd_pkg::RST_THRESHOLD;
      find_window <= psrpd_pkg::RST_FIND_WINDOW;
      scope_port  <= psrpd_pkg::RST_SCOPE_PORT;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        psrpd_pkg::REG_MODE:        mode        <= cfg_data[1:0];
        psrpd_pkg::REG_THRESHOLD:   threshold   <= cfg_data;
        psrpd_pkg::REG_FIND_WINDOW: find_window <= cfg_data;
        psrpd_pkg::REG_SCOPE_PORT:  scope_port  <= cfg_data[psrpd_pkg::PORT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [psrpd_pkg::COUNT_W-1:0] thr;
  logic [psrpd_pkg::TIME_W-1:0]  win;
  logic                          scan;
  assign thr  = (threshold == '0) ? psrpd_pkg::COUNT_W'(1) : threshold;
  assign win  = (find_window == '0) ? psrpd_pkg::TIME_W'(1) : find_window;
  assign scan = (mode == psrpd_pkg::MODE_PORTS);

  // Latched item.
  logic                         ver;
  logic [psrpd_pkg::ADDR_W-1:0] hi, lo;
  logic [psrpd_pkg::PORT_W-1:0] port;
  logic [psrpd_pkg::TIME_W-1:0] now;

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      ver  <= in_ver;
      hi   <= in_hi;
      lo   <= in_lo;
      port <= in_port;
      now  <= in_now;
    end
  end

  // XOR fold of the key into an index.
  logic [psrpd_pkg::ADDR_W-1:0] fold_v;
  logic [IDX_W-1:0]             hash;
  always_comb begin
    fold_v = hi ^ lo ^ psrpd_pkg::ADDR_W'(ver);
    hash   = '0;
    for (int k = 0; k < NCH; k++) begin
      hash = hash ^ IDX_W'(fold_v >> (k * IDX_W));
    end
  end

  // Slot table and port store.
  psrpd_pkg::row_t slot_mem [TABLE_DEPTH];
  logic [psrpd_pkg::PORT_W-1:0] port_mem [PDEPTH];
  psrpd_pkg::row_t rrow;
  logic [psrpd_pkg::PORT_W-1:0] prow;

  logic [IDX_W-1:0] cur_idx, prb_cnt, clr_idx, evict_ptr, best_idx, sel_slot;
  logic [SC_W-1:0]  evc_cnt;
  logic [psrpd_pkg::TIME_W-1:0] best_ts;
  logic [PI_W-1:0]  pidx;
  logic             sel_used, is_new, expired, held;
  psrpd_pkg::row_t  sel_row;

  psrpd_pkg::row_t  wrow;
  logic             slot_we, port_we;
  logic [IDX_W-1:0] slot_waddr;
  logic [PI_W-1:0]  port_wsub;

  always_ff @(posedge clk) begin
    rrow <= slot_mem[cur_idx];
    prow <= port_mem[{sel_slot, pidx}];
    if (slot_we) slot_mem[slot_waddr] <= wrow;
    if (port_we) port_mem[{sel_slot, port_wsub}] <= port;
  end

  // Status toward the controller.
  logic key_match, ts_better;
  logic [IDX_W-1:0] best_n;
  logic [psrpd_pkg::PCNT_W-1:0] pcnt_eff;
  assign key_match = (rrow.ver == ver) && (rrow.hi == hi) && (rrow.lo == lo);
  assign ts_better = (evc_cnt == '0) || (rrow.last < best_ts);
  assign best_n    = ts_better ? cur_idx : best_idx;
  assign pcnt_eff  = (sel_row.pcnt > PPS) ? PPS : sel_row.pcnt;

  always_comb begin
    st            = '0;
    st.clr_last   = (clr_idx == IDX_W'(TABLE_DEPTH - 1));
    st.ignored    = (mode == psrpd_pkg::MODE_OFF) || (scan && port == '0) ||
                    (mode == psrpd_pkg::MODE_SCOPED && scope_port != '0 &&
                     scope_port != port);
    st.prb_hit    = !rrow.used || key_match;
    st.prb_last   = (prb_cnt == IDX_W'(TABLE_DEPTH - 1));
    st.evc_free   = !rrow.used;
    st.evc_last   = (evc_cnt == SC_W'(EVICT_SCAN - 1));
    st.need_ports = scan && !is_new && !expired && (sel_row.pcnt != '0);
    st.prt_match  = (prow == port);
    st.prt_last   = ((psrpd_pkg::PCNT_W'(pidx) + psrpd_pkg::PCNT_W'(1)) == pcnt_eff);
    st.out_busy   = res.valid && !res.ready;
  end

  // Sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      evict_ptr <= '0;
    end else begin
      if (cmd.clr) clr_idx <= clr_idx + IDX_W'(1);
      if (cmd.evc_chk) begin
        if (!rrow.used) evict_ptr <= cur_idx + IDX_W'(1);
        else if (st.evc_last) evict_ptr <= best_n + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      held <= 1'b0;
    end
    if (cmd.prb_start) begin
      cur_idx <= hash;
      prb_cnt <= '0;
    end
    if (cmd.prb_chk) begin
      if (st.prb_hit) begin
        sel_slot <= cur_idx;
        sel_row  <= rrow;
        sel_used <= 1'b0;
        is_new   <= !rrow.used;
        expired  <= ((now - rrow.wstart) >= win);
      end else if (st.prb_last) begin
        cur_idx  <= evict_ptr;
        evc_cnt  <= '0;
        best_idx <= evict_ptr;
      end else begin
        cur_idx <= cur_idx + IDX_W'(1);
        prb_cnt <= prb_cnt + IDX_W'(1);
      end
    end
    if (cmd.evc_chk) begin
      is_new <= 1'b1;
      if (!rrow.used) begin
        sel_slot <= cur_idx;
        sel_used <= 1'b0;
      end else begin
        best_idx <= best_n;
        if (ts_better) best_ts <= rrow.last;
        if (st.evc_last) begin
          sel_slot <= best_n;
          sel_used <= 1'b1;
        end else begin
          cur_idx <= cur_idx + IDX_W'(1);
          evc_cnt <= evc_cnt + SC_W'(1);
        end
      end
    end
    if (cmd.prt_start) pidx <= '0;
    if (cmd.prt_chk) begin
      if (st.prt_match) held <= 1'b1;
      else pidx <= pidx + PI_W'(1);
    end
  end

  // Update of the selected slot and the result it gives.
  psrpd_pkg::outcome_t           u_outcome;
  logic                          u_trig;
  logic [psrpd_pkg::COUNT_W-1:0] u_count, ecnt_inc;
  logic [psrpd_pkg::PCNT_W-1:0]  pcnt_inc;
  logic                          u_port_we;

  assign ecnt_inc = (sel_row.ecnt == '1) ? sel_row.ecnt : sel_row.ecnt + psrpd_pkg::COUNT_W'(1);
  assign pcnt_inc = (sel_row.pcnt < PPS) ? sel_row.pcnt + psrpd_pkg::PCNT_W'(1) : sel_row.pcnt;

  always_comb begin
    wrow      = sel_row;
    wrow.last = now;
    u_outcome = psrpd_pkg::OUT_IGNORED;
    u_trig    = 1'b0;
    u_count   = '0;
    u_port_we = 1'b0;
    port_wsub = '0;
    if (is_new) begin
      wrow.used   = 1'b1;
      wrow.ver    = ver;
      wrow.hi     = hi;
      wrow.lo     = lo;
      wrow.wstart = now;
      wrow.ecnt   = scan ? '0 : psrpd_pkg::COUNT_W'(1);
      wrow.pcnt   = scan ? psrpd_pkg::PCNT_W'(1) : '0;
      u_port_we   = scan;
      u_outcome   = psrpd_pkg::OUT_NEW;
      u_count     = scan ? psrpd_pkg::COUNT_W'(1) : psrpd_pkg::COUNT_W'(1);
    end else if (expired) begin
      // Window ran out: restart it with this event as the first.
      wrow.wstart = now;
      if (scan) begin
        wrow.pcnt = psrpd_pkg::PCNT_W'(1);
        u_port_we = 1'b1;
      end else begin
        wrow.ecnt = psrpd_pkg::COUNT_W'(1);
      end
      u_outcome = psrpd_pkg::OUT_RESTART;
      u_count   = psrpd_pkg::COUNT_W'(1);
    end else if (scan) begin
      if (held) begin
        u_outcome = psrpd_pkg::OUT_SEEN;
        u_count   = psrpd_pkg::COUNT_W'(sel_row.pcnt);
      end else begin
        u_port_we = (sel_row.pcnt < PPS);
        port_wsub = sel_row.pcnt[PI_W-1:0];
        wrow.pcnt = pcnt_inc;
        if (psrpd_pkg::COUNT_W'(pcnt_inc) < thr) begin
          u_outcome = psrpd_pkg::OUT_COUNTED;
          u_count   = psrpd_pkg::COUNT_W'(pcnt_inc);
        end else begin
          u_outcome   = psrpd_pkg::OUT_TRIGGER;
          u_trig      = 1'b1;
          wrow.wstart = now;
          wrow.pcnt   = '0;
        end
      end
    end else begin
      wrow.ecnt = ecnt_inc;
      if (ecnt_inc < thr) begin
        u_outcome = psrpd_pkg::OUT_COUNTED;
        u_count   = ecnt_inc;
      end else begin
        u_outcome   = psrpd_pkg::OUT_TRIGGER;
        u_trig      = 1'b1;
        wrow.wstart = now;
        wrow.ecnt   = '0;
      end
    end
    if (cmd.clr) begin
      wrow      = sel_row;
      wrow.used = 1'b0;
    end
  end

  assign slot_we    = cmd.clr || (cmd.commit && !st.ignored);
  assign slot_waddr = cmd.clr ? clr_idx : sel_slot;
  assign port_we    = cmd.commit && !st.ignored && u_port_we;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.commit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (st.ignored) begin
        res.outcome        <= psrpd_pkg::OUT_IGNORED;
        res.trigger        <= 1'b0;
        res.count_value    <= '0;
        res.slot           <= '0;
        res.replaced_other <= 1'b0;
      end else begin
        res.outcome        <= u_outcome;
        res.trigger        <= u_trig;
        res.count_value    <= u_count;
        res.slot           <= sel_slot;
        res.replaced_other <= is_new && sel_used;
      end
    end
  end

endmodule

@@ design/per_source_rate_and_portscan_detector.sv @@
// Top level of the per-source rate and port-scan detector.
//
//   Channel   Direction  Carries
//   events    in         ip_version, addr_high, addr_low, dest_port, now_sec
//   results   out        outcome, trigger, count_value, slot, replaced_other
//   cfg_*     in         register writes: mode, threshold, find_window, scope_port
//
// After reset the block clears the in-use bit of every table slot, one slot per
// cycle, so it takes no item until every slot is cleared; config writes still land.
// An item takes an accept step, a start step, a read and a check per probed slot,
// a decide step, a read and a check per stored port checked in port-scan mode and
// an update step. A full table adds a read and a check per slot of the eviction
// scan, up to EVICT_SCAN slots. The slot table, read once per probe, sets the pace.
// Ignored items skip the probe and go from start to update. The result sits in an
// output register; the update waits only while it still holds an item not yet taken.
`timescale 1ns / 1ps
module per_source_rate_and_portscan_detector #(
  parameter int TABLE_DEPTH    = 1024,
  parameter int PORTS_PER_SLOT = 64,
  parameter int EVICT_SCAN     = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr,
  input  logic [psrpd_pkg::CIDX_W-1:0] cfg_index,
  input  logic [psrpd_pkg::CFG_W-1:0]  cfg_data,
  psrpd_item_if.sink                   events,
  psrpd_result_if.source               results
);

  // The controller and datapath talk only through these two bundles.
  psrpd_pkg::cmd_t    cmd;
  psrpd_pkg::status_t st;

  psrpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (events.valid),
    .in_ready (events.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath owns the table, the port store, the config registers and
  // the result register; the item payload is latched there on acceptance.
  psrpd_dp #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .PORTS_PER_SLOT (PORTS_PER_SLOT),
    .EVICT_SCAN     (EVICT_SCAN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ver    (events.ip_version),
    .in_hi     (events.addr_high),
    .in_lo     (events.addr_low),
    .in_port   (events.dest_port),
    .in_now    (events.now_sec),
    .cmd       (cmd),
    .st        (st),
    .res       (results)
  );

endmodule

@@ verif/tb_per_source_rate_and_portscan_detector.sv @@
// Self-checking testbench for the per-source rate and port-scan detector.
`timescale 1ns / 1ps

class scan_scoreboard;
  typedef struct packed {
    logic [2:0]  outcome;
    logic        trigger;
    logic [31:0] count_value;
    logic [9:0]  slot;
    logic        replaced_other;
  } verdict_t;

  // Shadow copy of the detector's configuration.
  logic [1:0]  mode;
  logic [31:0] threshold;
  logic [31:0] find_window;
  logic [15:0] scope_port;

  // Shadow copy of the per-source table.
  bit          used[1024];
  bit          ver[1024];
  bit [63:0]   hi[1024];
  bit [63:0]   lo[1024];
  bit [31:0]   wstart[1024];
  bit [31:0]   ecnt[1024];
  bit [6:0]    pcnt[1024];
  bit [31:0]   last[1024];
  bit [15:0]   ports[1024][64];
  bit [9:0]    evict_ptr;

  verdict_t    pending[$];
  int          errors;

  function new();
    mode = psrpd_pkg::RST_MODE;
    threshold = psrpd_pkg::RST_THRESHOLD;
    find_window = psrpd_pkg::RST_FIND_WINDOW;
    scope_port = psrpd_pkg::RST_SCOPE_PORT;
    foreach (used[i]) used[i] = 0;
    evict_ptr = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      psrpd_pkg::REG_MODE:        mode = val[1:0];
      psrpd_pkg::REG_THRESHOLD:   threshold = val;
      psrpd_pkg::REG_FIND_WINDOW: find_window = val;
      default:                    scope_port = val[15:0];
    endcase
  endfunction

  function bit [9:0] fold_hash(bit v, bit [63:0] h, bit [63:0] l);
    bit [63:0] x;
    bit [9:0]  r;
    x = h ^ l ^ {63'd0, v};
    r = 0;
    while (x != 0) begin
      r ^= x[9:0];
      x >>= 10;
    end
    return r;
  endfunction

  function bit owns(bit [9:0] s, bit v, bit [63:0] h, bit [63:0] l);
    return ver[s] == v && hi[s] == h && lo[s] == l;
  endfunction

  // Linear probe from the hash; on a full table, scan from the eviction cursor.
  function bit [9:0] locate(bit v, bit [63:0] h, bit [63:0] l);
    bit [9:0]  base, s, best;
    bit [31:0] best_ts;
    base = fold_hash(v, h, l);
    for (int i = 0; i < 1024; i++) begin
      s = base + 10'(i);
      if (!used[s] || owns(s, v, h, l)) return s;
    end
    best = evict_ptr;
    best_ts = last[best];
    for (int i = 0; i < 64; i++) begin
      s = evict_ptr + 10'(i);
      if (!used[s]) begin
        evict_ptr = s + 10'd1;
        return s;
      end
      if (last[s] < best_ts) begin
        best_ts = last[s];
        best = s;
      end
    end
    evict_ptr = best + 10'd1;
    return best;
  endfunction

  function void note_event(bit v, bit [63:0] h, bit [63:0] l, bit [15:0] port,
                           bit [31:0] now);
    verdict_t  r;
    bit [31:0] thr, win;
    bit        scan, held;
    bit [9:0]  s;
    thr = (threshold != 0) ? threshold : 32'd1;
    win = (find_window != 0) ? find_window : 32'd1;
    scan = (mode == psrpd_pkg::MODE_PORTS);
    r = '0;
    if (mode == psrpd_pkg::MODE_OFF || (scan && port == 0) ||
        (mode == psrpd_pkg::MODE_SCOPED && scope_port != 0 && scope_port != port)) begin
      r.outcome = psrpd_pkg::OUT_IGNORED;
    end else begin
      s = locate(v, h, l);
      r.slot = s;
      if (!used[s] || !owns(s, v, h, l)) begin
        r.replaced_other = used[s];
        used[s] = 1;
        ver[s] = v;
        hi[s] = h;
        lo[s] = l;
        wstart[s] = now;
        last[s] = now;
        ecnt[s] = scan ? 32'd0 : 32'd1;
        pcnt[s] = scan ? 7'd1 : 7'd0;
        if (scan) ports[s][0] = port;
        r.outcome = psrpd_pkg::OUT_NEW;
      end else begin
        last[s] = now;
        if (32'(now - wstart[s]) >= win) begin
          wstart[s] = now;
          if (scan) begin
            pcnt[s] = 7'd1;
            ports[s][0] = port;
          end else begin
            ecnt[s] = 32'd1;
          end
          r.outcome = psrpd_pkg::OUT_RESTART;
        end else if (scan) begin
          held = 0;
          for (int i = 0; i < 64 && i < pcnt[s]; i++)
            if (ports[s][i] == port) held = 1;
          if (held) begin
            r.outcome = psrpd_pkg::OUT_SEEN;
          end else begin
            // A full port list stops storing and its count stops growing, but is still checked against the threshold.
            if (pcnt[s] < 64) begin
              ports[s][pcnt[s]] = port;
              pcnt[s]++;
            end
            if (32'(pcnt[s]) < thr) begin
              r.outcome = psrpd_pkg::OUT_COUNTED;
            end else begin
              r.outcome = psrpd_pkg::OUT_TRIGGER;
              r.trigger = 1;
              wstart[s] = now;
              pcnt[s] = 7'd0;
            end
          end
        end else begin
          if (ecnt[s] != 32'hFFFF_FFFF) ecnt[s]++;
          if (ecnt[s] < thr) begin
            r.outcome = psrpd_pkg::OUT_COUNTED;
          end else begin
            r.outcome = psrpd_pkg::OUT_TRIGGER;
            r.trigger = 1;
            wstart[s] = now;
            ecnt[s] = 32'd0;
          end
        end
      end
      r.count_value = scan ? 32'(pcnt[s]) : ecnt[s];
    end
    pending.push_back(r);
  endfunction

  function void check_verdict(verdict_t got);
    verdict_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result item %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.outcome !== want.outcome) begin
      $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, got.outcome);
      errors++;
    end
    if (got.trigger !== want.trigger) begin
      $display("%0t: trigger expected %0d actual %0d", $time, want.trigger, got.trigger);
      errors++;
    end
    if (got.count_value !== want.count_value) begin
      $display("%0t: count_value expected %0d actual %0d", $time, want.count_value,
               got.count_value);
      errors++;
    end
    if (got.slot !== want.slot) begin
      $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
      errors++;
    end
    if (got.replaced_other !== want.replaced_other) begin
      $display("%0t: replaced_other expected %0d actual %0d", $time, want.replaced_other,
               got.replaced_other);
      errors++;
    end
  endfunction
endclass

module tb_per_source_rate_and_portscan_detector;

  localparam logic [1:0] MODE_UNUSED = psrpd_pkg::MODE_OFF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int POOL_N = 32;

  logic                         clk;
  logic                         rst;
  logic                         cfg_wr;
  logic [psrpd_pkg::CIDX_W-1:0] cfg_index;
  logic [psrpd_pkg::CFG_W-1:0]  cfg_data;

  psrpd_item_if ev ();
  psrpd_result_if #(.SLOT_W(10)) rs ();

  per_source_rate_and_portscan_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .events    (ev),
    .results   (rs)
  );

  scan_scoreboard board;

  // When quiet is set neither side idles; the closing phase runs this way.
  bit        quiet;
  int        cycles;
  int        stall_left;

  // A pool of recurring sources so that windows fill up and triggers fire.
  bit        pool_ver[POOL_N];
  bit [63:0] pool_hi[POOL_N];
  bit [63:0] pool_lo[POOL_N];
  bit [31:0] clock_sec;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Every accepted item is handed to the predictor, and every accepted result is
  // checked against the oldest prediction. Inputs only move at the falling edge,
  // so the values seen here are settled.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (ev.valid && ev.ready)
      board.note_event(ev.ip_version, ev.addr_high, ev.addr_low, ev.dest_port, ev.now_sec);
    if (rs.valid && rs.ready)
      board.check_verdict({rs.outcome, rs.trigger, rs.count_value, rs.slot,
                           rs.replaced_other});
  end

  // The result side stalls in random bursts.
  always @(negedge clk) begin
    if (rst || quiet) begin
      rs.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rs.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      rs.ready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      rs.ready <= 1'b1;
    end
  end

  task automatic reg_write(logic [psrpd_pkg::CIDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
  endtask

  task automatic idle_sender();
    @(negedge clk);
    ev.valid <= 1'b0;
  endtask

  // Registers may only change while the block is idle: drop valid, wait for the
  // last result and then a few more cycles so that the output register has drained.
  task automatic wait_drained();
    idle_sender();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] m, logic [31:0] thr, logic [31:0] win,
                           logic [15:0] sp);
    wait_drained();
    reg_write(psrpd_pkg::REG_MODE, {30'd0, m});
    reg_write(psrpd_pkg::REG_THRESHOLD, thr);
    reg_write(psrpd_pkg::REG_FIND_WINDOW, win);
    reg_write(psrpd_pkg::REG_SCOPE_PORT, {16'd0, sp});
    @(negedge clk);
    cfg_wr <= 1'b0;
  endtask

  // Offers one item, with an optional idle burst first, and holds it until taken.
  // Valid is left high so that back-to-back items never drop it in between.
  task automatic send_event(bit v, bit [63:0] h, bit [63:0] l, bit [15:0] port,
                            bit [31:0] now);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      @(negedge clk);
      ev.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    ev.valid <= 1'b1;
    ev.ip_version <= v;
    ev.addr_high <= h;
    ev.addr_low <= l;
    ev.dest_port <= port;
    ev.now_sec <= now;
    do @(posedge clk); while (!ev.ready);
  endtask

  // One event from a pool source, or now and then from a fresh one. Ports come
  // mostly from a short list so that repeats and the scope port are common.
  task automatic pool_event(logic [15:0] sp);
    int        k;
    bit [15:0] port;
    k = $urandom_range(0, POOL_N - 1);
    case ($urandom_range(0, 5))
      0: port = sp;
      1: port = 16'($urandom);
      2: port = 16'd0;
      default: port = 16'd1 + 16'($urandom_range(0, 11));
    endcase
    if ($urandom_range(0, 19) == 0)
      clock_sec = $urandom;
    else
      clock_sec = clock_sec + $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0)
      send_event(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom},
                 port, clock_sec);
    else
      send_event(pool_ver[k], pool_hi[k], pool_lo[k], port, clock_sec);
  endtask

  initial begin
    logic [1:0]  m;
    logic [31:0] thr, win;
    logic [15:0] sp;

    board = new();
    quiet = 0;
    cycles = 0;
    stall_left = 0;
    rst = 1'b1;
    cfg_wr = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    ev.valid = 1'b0;
    ev.ip_version = 1'b0;
    ev.addr_high = '0;
    ev.addr_low = '0;
    ev.dest_port = '0;
    ev.now_sec = '0;
    rs.ready = 1'b1;
    clock_sec = 32'd100;
    for (int i = 0; i < POOL_N; i++) begin
      pool_ver[i] = 1'($urandom_range(0, 1));
      pool_hi[i] = pool_ver[i] ? {$urandom, $urandom} : 64'd0;
      pool_lo[i] = pool_ver[i] ? {$urandom, $urandom} : {32'd0, $urandom};
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset configuration: field extremes first.
    send_event(1'b0, 64'd0, 64'd0, 16'd0, 32'd0);
    send_event(1'b1, '1, '1, '1, '1);
    send_event(1'b1, '1, '1, 16'd80, 32'd3);
    send_event(1'b0, 64'd0, 64'd0, 16'd80, 32'd5);
    // Time running backwards gives a wrapped, huge window age.
    send_event(1'b0, 64'd0, 64'd0, 16'd80, 32'd1);

    // A zero threshold and a zero window both act as one.
    configure(psrpd_pkg::MODE_RATE, 32'd0, 32'd0, 16'd0);
    send_event(1'b0, 64'd0, 64'd7, 16'd22, 32'd50);
    send_event(1'b0, 64'd0, 64'd7, 16'd22, 32'd50);
    send_event(1'b0, 64'd0, 64'd7, 16'd22, 32'd51);

    // Scoped rate: matching port counts, another port is ignored.
    configure(psrpd_pkg::MODE_SCOPED, 32'd2, 32'd100, 16'd443);
    send_event(1'b1, 64'h1, 64'h2, 16'd443, 32'd10);
    send_event(1'b1, 64'h1, 64'h2, 16'd80, 32'd11);
    send_event(1'b1, 64'h1, 64'h2, 16'd443, 32'd12);

    // The unused mode ignores everything.
    configure(MODE_UNUSED, 32'd1, 32'd1, 16'd0);
    send_event(1'b0, 64'd0, 64'd9, 16'd9, 32'd9);

    // Port-scan mode: port zero ignored, repeats seen, and a list that overflows
    // its 64 entries, where the count stops at 64, below a higher threshold.
    configure(psrpd_pkg::MODE_PORTS, 32'd70, 32'hFFFF_FFFF, 16'd0);
    send_event(1'b0, 64'd0, 64'h55, 16'd0, 32'd1000);
    for (int p = 1; p <= 72; p++)
      send_event(1'b0, 64'd0, 64'h55, 16'(p), 32'd1000);
    send_event(1'b0, 64'd0, 64'h55, 16'd3, 32'd1001);
    send_event(1'b0, 64'd0, 64'h55, 16'd71, 32'd1001);

    // Random phases, each under its own configuration, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      m = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 2));
      case (ph)
        0: thr = 32'hFFFF_FFFF;
        1: thr = 32'd1;
        default: thr = $urandom_range(0, 8);
      endcase
      case (ph)
        2: win = 32'hFFFF_FFFF;
        3: win = 32'd1;
        default: win = $urandom_range(0, 20);
      endcase
      sp = (ph == 5) ? 16'hFFFF : (($urandom_range(0, 1) == 0) ? 16'd0 : 16'd5);
      configure(m, thr, win, sp);
      for (int n = 0; n < 55; n++) begin
        pool_event(sp);
        // Hold off once until the block has answered everything.
        if (ph == 4 && n == 30) begin
          idle_sender();
          while (board.pending.size() != 0) @(posedge clk);
        end
      end
    end

    // Closing phase without idling: many distinct sources that hash to distinct
    // slots, then a mix of repeats and fresh sources.
    quiet = 1;
    configure(psrpd_pkg::MODE_RATE, 32'd1000, 32'd1000, 16'd0);
    for (int i = 0; i < 150; i++) begin
      clock_sec = clock_sec + $urandom_range(0, 1);
      send_event(1'b0, 64'd0, 64'(i), 16'd1, clock_sec);
    end
    for (int i = 0; i < 30; i++) begin
      clock_sec = clock_sec + $urandom_range(0, 1);
      if (i % 3 == 0)
        send_event(1'b0, 64'd0, 64'($urandom_range(0, 149)), 16'd1, clock_sec);
      else
        send_event(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 16'd2, clock_sec);
    end
    idle_sender();

    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ per_source_rate_and_portscan_detector.f @@
design/psrpd_pkg.sv
design/psrpd_item_if.sv
design/psrpd_result_if.sv
design/psrpd_ctrl.sv
design/psrpd_dp.sv
design/per_source_rate_and_portscan_detector.sv
verif/tb_per_source_rate_and_portscan_detector.sv
